### src/isr_pkg.sv
// Shared types and codes for the integer set insert/remove unit.
// No dependencies; imported by every module of the unit.
package isr_pkg;

  // Request operation codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_FINISH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;   // capture request, restart the scan
    logic scan;     // issue table reads and compare
    logic update;   // apply the request to the table
    logic load;     // move the result into the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic scan_last;  // last entry is being compared this cycle
    logic out_free;   // output register can take a result this cycle
  } stat_t;

  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned CountWidth = 5;

endpackage

### src/isr_ctrl.sv
// Controller state machine for the integer set insert/remove unit.
// Depends on isr_pkg for state, command and status types.
module isr_ctrl import isr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        // hold the result until the output register frees up
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### src/isr_dp.sv
// Datapath for the integer set insert/remove unit: value memory, valid
// marks, member count, linear scan and output register. Uses isr_pkg.
module isr_dp import isr_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output stat_t                      stat_o,
  input  logic                       op_i,
  input  logic signed [KeyWidth-1:0] key_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 status_o,
  output logic [CountWidth-1:0]      member_count_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // Stored values; only valid entries are ever compared
  logic [KeyWidth-1:0] mem_q [CAPACITY];
  logic [CAPACITY-1:0] valid_q;
  logic [CntW-1:0]     count_q;

  // Captured request
  logic                op_q;
  logic [KeyWidth-1:0] key_q;

  // Scan pipeline
  logic [CntW-1:0]     issue_q;
  logic                issue_go;
  logic [IdxW-1:0]     issue_idx;
  logic [KeyWidth-1:0] rd_q;
  logic                rd_vld_q;
  logic                cmp_act_q;
  logic [IdxW-1:0]     cmp_idx_q;
  logic                hit_q;
  logic [IdxW-1:0]     hit_idx_q;
  logic                free_q;
  logic [IdxW-1:0]     free_idx_q;
  logic                cmp_hit;

  // Update outcome
  status_e             res_d;
  status_e             res_q;
  logic                mem_we;

  // Output register
  logic                out_valid_q;
  logic [2:0]          status_q;
  logic [CountWidth-1:0] count_out_q;

  assign issue_go  = cmd_i.scan && (issue_q != CntW'(CAPACITY));
  assign issue_idx = issue_q[IdxW-1:0];
  assign cmp_hit   = cmp_act_q && rd_vld_q && (rd_q == key_q);

  assign stat_o.scan_last = cmp_act_q && (cmp_idx_q == IdxW'(CAPACITY - 1));
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_i;
      key_q <= key_i;
    end
  end

  // Memory: one registered read, one write
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[free_idx_q] <= key_q;
    end
    rd_q <= mem_q[issue_idx];
  end

  // Scan control: issue one address per cycle, compare in the next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q    <= '0;
      cmp_act_q  <= 1'b0;
      cmp_idx_q  <= '0;
      rd_vld_q   <= 1'b0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        issue_q <= '0;
        hit_q   <= 1'b0;
        free_q  <= 1'b0;
      end else if (issue_go) begin
        issue_q <= issue_q + 1'b1;
      end
      cmp_act_q <= issue_go;
      cmp_idx_q <= issue_idx;
      rd_vld_q  <= valid_q[issue_idx];
      // record the match and the lowest free entry
      if (cmp_hit && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= cmp_idx_q;
      end
      if (cmp_act_q && !rd_vld_q && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= cmp_idx_q;
      end
    end
  end

  // Decide the outcome of the request
  always_comb begin
    mem_we = 1'b0;
    res_d  = ST_NOT_FOUND;
    if (op_e'(op_q) == OP_INSERT) begin
      if (hit_q) begin
        res_d = ST_DUPLICATE;
      end else if (free_q) begin
        res_d  = ST_INSERTED;
        mem_we = cmd_i.update;
      end else begin
        res_d = ST_FULL;
      end
    end else begin
      res_d = hit_q ? ST_REMOVED : ST_NOT_FOUND;
    end
  end

  // Apply the request to valid marks and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      res_q   <= ST_INSERTED;
    end else if (cmd_i.update) begin
      res_q <= res_d;
      if (res_d == ST_INSERTED) begin
        valid_q[free_idx_q] <= 1'b1;
        count_q             <= count_q + 1'b1;
      end else if (res_d == ST_REMOVED) begin
        valid_q[hit_idx_q] <= 1'b0;
        count_q            <= count_q - 1'b1;
      end
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      status_q    <= res_q;
      count_out_q <= CountWidth'(count_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign member_count_o = count_out_q;

  // Count tracks the valid marks
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("member count differs from number of valid entries");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= int'(CAPACITY))
    else $error("member count above capacity");

  a_dup_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update && hit_q && (op_e'(op_q) == OP_INSERT) |=> $stable(count_q))
    else $error("duplicate insert changed the count");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending one");

endmodule

### src/integer_set_insert_remove_unit.sv
// Top level of the integer set insert/remove unit.
// Joins isr_ctrl and isr_dp; uses isr_pkg.
//
// Holds up to CAPACITY distinct signed 32-bit values. Each request on the
// input channel (in_valid_i / in_stall_o, fields op_i and key_i) asks to
// insert (op 0) or remove (op 1) key_i. Each request yields one result on
// the output channel (out_valid_o / out_stall_i): status_o (inserted,
// duplicate, removed, not found, full) and member_count_o after the step.
// A transfer happens on a clock edge with valid high and stall low.
// A request walks the value memory one entry per cycle through its single
// read port. Only one request is in flight; the output register lets a new
// request be taken while the previous result still waits. If the receiver
// stalls with a result pending, the next result waits in the datapath and
// requests stop until the output register frees.
// Reset (rst_ni low, asynchronous) empties the set and the output register;
// no clearing pass is needed, since the valid marks are flip-flops.
module integer_set_insert_remove_unit import isr_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       op_i,
  input  logic signed [KeyWidth-1:0] key_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 status_o,
  output logic [CountWidth-1:0]      member_count_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequence each request
  isr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Table, scan and result
  isr_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (op_i),
    .key_i          (key_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .member_count_o (member_count_o)
  );

endmodule

### dv/integer_set_insert_remove_unit_tb.sv
// Testbench for integer_set_insert_remove_unit: random and directed insert/remove
// requests, checked against a mirror of the set kept in a small scoreboard class.
// Depends on isr_pkg and the unit itself, which in turn needs isr_ctrl and isr_dp.
`timescale 1ns / 100ps

module integer_set_insert_remove_unit_tb;
  import isr_pkg::*;

  localparam int unsigned CAPACITY      = 16;
  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned RANDOM_ITEMS  = 850;
  localparam int unsigned POOL_SIZE     = 24;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned MAX_PRINTED   = 50;

  // One expected result of the set
  typedef struct packed {
    status_e               status;
    logic [CountWidth-1:0] count;
  } set_result_t;

  // Mirror of the set contents and the queue of results still owed by the unit
  class set_scoreboard;
    logic [KeyWidth-1:0] slot_key [CAPACITY];
    bit                  slot_used [CAPACITY];
    int unsigned         members;
    set_result_t         owed_q [$];
    int unsigned         errors;

    function new();
      members = 0;
      errors  = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    // Apply an accepted request to the mirror and queue its result
    function void note_request(op_e op, logic [KeyWidth-1:0] key);
      int          hit;
      int          free_slot;
      set_result_t res;
      hit       = -1;
      free_slot = -1;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
        if (slot_used[i] && slot_key[i] == key) hit = i;
        if (!slot_used[i]) free_slot = i;
      end
      if (op == OP_INSERT) begin
        if (hit >= 0) begin
          res.status = ST_DUPLICATE;
        end else if (free_slot >= 0) begin
          slot_key[free_slot]  = key;
          slot_used[free_slot] = 1'b1;
          members++;
          res.status = ST_INSERTED;
        end else begin
          res.status = ST_FULL;
        end
      end else begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          members--;
          res.status = ST_REMOVED;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      res.count = members[CountWidth-1:0];
      owed_q.push_back(res);
    endfunction

    // Print one line per mismatch, up to a cap, and count every one
    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Compare a delivered result with the oldest one owed
    task check_result(logic [2:0] status, logic [CountWidth-1:0] count);
      set_result_t exp_res;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d count=%0d", status, count));
      end else begin
        exp_res = owed_q.pop_front();
        if (status !== exp_res.status)
          report_mismatch($sformatf("status %0d, expected %0d (%s)", status,
                                    exp_res.status, exp_res.status.name()));
        if (count !== exp_res.count)
          report_mismatch($sformatf("member count %0d, expected %0d", count, exp_res.count));
      end
    endtask

    // Flag any result that never arrived
    task flush_leftovers();
      while (owed_q.size() != 0) begin
        report_mismatch($sformatf("result never delivered, expected status %s count %0d",
                                  owed_q[0].status.name(), owed_q[0].count));
        void'(owed_q.pop_front());
      end
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic                       op_i;
  logic signed [KeyWidth-1:0] key_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [2:0]                 status_o;
  logic [CountWidth-1:0]      member_count_o;

  set_scoreboard       set_sb;
  int unsigned         cycle_count;
  int unsigned         results_seen;
  bit                  sender_quiet;
  bit                  long_hold_done;
  logic [KeyWidth-1:0] key_pool [POOL_SIZE];

  integer_set_insert_remove_unit #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .key_i         (key_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .member_count_o(member_count_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Check every result taken from the unit
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      set_sb.check_result(status_o, member_count_o);
    end
  end

  // Gap between requests: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (sender_quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stall length; zero leaves a stretch without stalls
  function automatic int unsigned pick_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 65) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request, hold it until taken, then idle for the given gap
  task automatic send_request(op_e op, logic [KeyWidth-1:0] key, int unsigned gap);
    in_valid_i <= 1'b1;
    op_i       <= op;
    key_i      <= key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    set_sb.note_request(op, key);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Extremes, duplicates, removal of the only member, and a full table
  task automatic run_directed();
    send_request(OP_INSERT, 32'h8000_0000, pick_gap());
    send_request(OP_INSERT, 32'h8000_0000, pick_gap());
    send_request(OP_REMOVE, 32'h0000_0005, pick_gap());
    send_request(OP_REMOVE, 32'h8000_0000, pick_gap());
    send_request(OP_REMOVE, 32'h8000_0000, pick_gap());
    send_request(OP_INSERT, 32'h7FFF_FFFF, pick_gap());
    send_request(OP_INSERT, 32'h0000_0000, pick_gap());
    send_request(OP_INSERT, 32'hFFFF_FFFF, pick_gap());
    send_request(OP_INSERT, 32'h8000_0000, pick_gap());
    for (int i = 1; i <= 12; i++) send_request(OP_INSERT, i * 32'h1111_1111, pick_gap());
    // table is full now
    send_request(OP_INSERT, 32'h5555_AAAA, pick_gap());
    send_request(OP_INSERT, 32'h0000_0000, pick_gap());
    send_request(OP_REMOVE, 32'h3333_3333, pick_gap());
    send_request(OP_INSERT, 32'h5555_AAAA, pick_gap());
  endtask

  // Phases that lean to insert or remove so the set swings between empty and full
  task automatic run_random();
    int unsigned         lean;
    int unsigned         insert_pct;
    int unsigned         r;
    logic [KeyWidth-1:0] key;
    op_e                 op;
    lean = 2;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) begin
        lean         = $urandom_range(0, 2);
        sender_quiet = ($urandom_range(0, 3) == 0);
      end
      case (lean)
        0:       insert_pct = 80;
        1:       insert_pct = 20;
        default: insert_pct = 50;
      endcase
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      r  = $urandom_range(0, 99);
      if (r < 85) begin
        key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (r < 93) begin
        // near miss: one bit away from a pool value
        key = key_pool[$urandom_range(0, POOL_SIZE - 1)] ^ (32'h1 << $urandom_range(0, 31));
      end else begin
        key = $urandom();
      end
      send_request(op, key, pick_gap());
    end
    sender_quiet = 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off while requests keep coming
  initial begin
    int unsigned free_run;
    int unsigned hold;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      repeat (free_run) @(posedge clk_i);
      if (!long_hold_done && results_seen >= 150) begin
        hold           = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        hold = pick_stall();
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Reset, stimulus, drain and verdict
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    op_i           = 1'b0;
    key_i          = '0;
    cycle_count    = 0;
    results_seen   = 0;
    sender_quiet   = 1'b0;
    long_hold_done = 1'b0;
    set_sb         = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    in_valid_i <= 1'b0;
    while (set_sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);
    set_sb.flush_leftovers();
    if (set_sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
